// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl files
// every macro expects clk in scope, DSLD_ASSERT also expects rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off during reset
`define DSLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check, also active while reset is held
`define DSLD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/dsld_pkg.sv =====
// ----------------------------------------------------------------------------
// dsld_pkg
// shared constants and types of the dual sync length deframer
// ----------------------------------------------------------------------------
`default_nettype none

package dsld_pkg;

    // sync bytes
    localparam logic [7:0] SYNC_MSG_A = 8'hAB;
    localparam logic [7:0] SYNC_MSG_B = 8'hCD;
    localparam logic [7:0] SYNC_RAW_A = 8'hEA;
    localparam logic [7:0] SYNC_RAW_B = 8'hCE;

    // parse phases
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_MSG_B = 3'd1;
    localparam logic [2:0] PH_RAW_B = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_SKIP  = 3'd5;

    // event codes
    localparam logic [1:0] EV_DATA     = 2'd0;
    localparam logic [1:0] EV_EMPTY    = 2'd1;
    localparam logic [1:0] EV_SYNCERR  = 2'd2;
    localparam logic [1:0] EV_OVERSIZE = 2'd3;

    localparam logic [31:0] MAX_LEN_RESET = 32'd65535;

    // one parse result
    typedef struct packed {
        logic       hit;
        logic [1:0] event_code;
        logic [7:0] data;
        logic       kind;
        logic       last;
    } dsld_res_t;

    // input stage contents
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } dsld_in_t;

endpackage

`default_nettype wire

// ===== hdl/dsld_in_reg.sv =====
// ----------------------------------------------------------------------------
// dsld_in_reg
// input register: holds one received byte until the parser takes it
// ----------------------------------------------------------------------------
`default_nettype none

module dsld_in_reg
    import dsld_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] rx_byte,
    input  wire logic       take,
    output logic            in_stall,
    output dsld_in_t        stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    // free slot when empty or being drained this cycle
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/dsld_parser.sv =====
// ----------------------------------------------------------------------------
// dsld_parser
// phase machine: sync hunt, length gather, payload count
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dsld_parser
    import dsld_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [7:0]  data,
    input  wire logic [31:0] max_len,
    output dsld_res_t        res
);

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic        kind_reg;
    logic        kind_next;
    logic [23:0] len_accum_reg;
    logic [23:0] len_accum_next;
    logic [1:0]  len_idx_reg;
    logic [1:0]  len_idx_next;
    logic [31:0] remain_reg;
    logic [31:0] remain_next;
    logic [31:0] remain_dec;
    logic [31:0] len_full;
    logic        in_count_phase;
    logic        len_more;

    assign remain_dec = remain_reg - 32'd1;
    assign len_full   = {data, len_accum_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        len_accum_next = len_accum_reg;
        len_idx_next   = len_idx_reg;
        remain_next    = remain_reg;
        res.hit        = 1'b0;
        res.event_code = EV_DATA;
        res.data       = 8'h00;
        res.kind       = kind_reg;
        res.last       = 1'b0;

        case (phase_reg)
            PH_MSG_B, PH_RAW_B:
            begin
                if (data == ((phase_reg == PH_MSG_B) ? SYNC_MSG_B : SYNC_RAW_B))
                begin
                    phase_next     = PH_LEN;
                    len_accum_next = 24'd0;
                    len_idx_next   = 2'd0;
                end
                else
                begin
                    phase_next     = PH_HUNT;
                    res.hit        = 1'b1;
                    res.event_code = EV_SYNCERR;
                end
            end
            PH_LEN:
            begin
                // little-endian length, one byte per item
                case (len_idx_reg)
                    2'd0:    len_accum_next = {16'd0, data};
                    2'd1:    len_accum_next = {8'd0, data, len_accum_reg[7:0]};
                    2'd2:    len_accum_next = {data, len_accum_reg[15:0]};
                    default: len_accum_next = len_accum_reg;
                endcase
                if (len_idx_reg != 2'd3)
                begin
                    len_idx_next = len_idx_reg + 2'd1;
                end
                else
                begin
                    len_idx_next = 2'd0;
                    remain_next  = len_full;
                    if (len_full == 32'd0)
                    begin
                        phase_next     = PH_HUNT;
                        res.hit        = 1'b1;
                        res.event_code = EV_EMPTY;
                        res.last       = 1'b1;
                    end
                    else if (len_full > max_len)
                    begin
                        phase_next     = PH_SKIP;
                        res.hit        = 1'b1;
                        res.event_code = EV_OVERSIZE;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                remain_next    = remain_dec;
                res.hit        = 1'b1;
                res.event_code = EV_DATA;
                res.data       = data;
                res.last       = (remain_dec == 32'd0);
                if (remain_dec == 32'd0)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_SKIP:
            begin
                remain_next = remain_dec;
                if (remain_dec == 32'd0)
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                // hunting, also any unused code
                if (data == SYNC_MSG_A)
                begin
                    kind_next  = 1'b0;
                    phase_next = PH_MSG_B;
                end
                else if (data == SYNC_RAW_A)
                begin
                    kind_next  = 1'b1;
                    phase_next = PH_RAW_B;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            kind_reg      <= 1'b0;
            len_accum_reg <= 24'd0;
            len_idx_reg   <= 2'd0;
            remain_reg    <= 32'd0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            len_accum_reg <= len_accum_next;
            len_idx_reg   <= len_idx_next;
            remain_reg    <= remain_next;
        end
    end

    assign in_count_phase = (phase_reg == PH_DATA) || (phase_reg == PH_SKIP);
    assign len_more       = (phase_reg == PH_LEN) && (len_idx_reg != 2'd3);

    // a counted phase never holds an exhausted count
    `DSLD_ASSERT(a_count_live, in_count_phase |-> (remain_reg != 32'd0), "count exhausted")
    // length bytes before the fourth keep gathering
    `DSLD_ASSERT(a_len_gather, (fire && len_more) |=> (phase_reg == PH_LEN), "length cut short")

endmodule

`default_nettype wire

// ===== hdl/dsld_out_reg.sv =====
// ----------------------------------------------------------------------------
// dsld_out_reg
// result register: holds one result until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module dsld_out_reg
    import dsld_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire dsld_res_t  res,
    input  wire logic       out_stall,
    output logic            out_valid,
    output logic            free,
    output logic [1:0]      event_res,
    output logic [7:0]      payload_byte,
    output logic            frame_kind,
    output logic            last_of_frame
);

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] event_reg;
    logic [7:0] byte_reg;
    logic       kind_reg;
    logic       last_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_reg <= res.event_code;
            byte_reg  <= res.data;
            kind_reg  <= res.kind;
            last_reg  <= res.last;
        end
    end

    assign out_valid     = valid_reg;
    assign event_res     = event_reg;
    assign payload_byte  = byte_reg;
    assign frame_kind    = kind_reg;
    assign last_of_frame = last_reg;

endmodule

`default_nettype wire

// ===== hdl/dual_sync_length_deframer.sv =====
// ----------------------------------------------------------------------------
// dual_sync_length_deframer
// deframes a byte stream into message frames (sync AB CD) and raw frames
// (sync EA CE), each with a 4-byte little-endian length and payload
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   in        sink        in_valid/in_stall    rx_byte
//   out       source      out_valid/out_stall  event_res, payload_byte,
//                                              frame_kind, last_of_frame
//   cfg       sink        cfg_we               cfg_wdata (max payload length)
//
// one item per cycle while out_stall is low; a byte goes input register ->
// phase logic -> result register, so a result is presented the cycle after its
// byte is taken; reset: hunting for a first sync byte, max payload length 65535
// while the result register waits on out_stall the input register still
// takes one more byte, then in_stall rises until the result is taken
// bytes that give no result (sync, length, dropped payload) wait on out too
//
`default_nettype none
`include "assert_macros.svh"

module dual_sync_length_deframer
    import dsld_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input bytes
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // results
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       event_res,
    output logic [7:0]       payload_byte,
    output logic             frame_kind,
    output logic             last_of_frame,
    // max payload length register
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    dsld_in_t    stage;
    dsld_res_t   res;
    logic        out_free;
    logic        fire;
    logic        load;
    logic [31:0] max_len_reg;

    // config register, to be written only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // the held byte moves on whenever the result register has room
    assign fire = stage.valid && out_free;
    // only bytes that produce an event fill the result register
    assign load = fire && res.hit;

    dsld_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .rx_byte  (rx_byte),
        .take     (fire),
        .in_stall (in_stall),
        .stage    (stage)
    );

    dsld_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .data    (stage.data),
        .max_len (max_len_reg),
        .res     (res)
    );

    dsld_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .res           (res),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .free          (out_free),
        .event_res     (event_res),
        .payload_byte  (payload_byte),
        .frame_kind    (frame_kind),
        .last_of_frame (last_of_frame)
    );

    // a loaded result is presented next cycle
    `DSLD_ASSERT(a_load_shows, load |=> out_valid, "loaded result not presented")
    // input back-pressure only while a byte is held and cannot move on
    `DSLD_ASSERT_ALWAYS(a_stall_cause, in_stall |-> (stage.valid && !out_free), "no stall cause")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the dual sync length deframer byte by byte: a software copy of the
// frame parser predicts every result, random frames, noise and broken syncs
// are pushed through under several payload limits and stall patterns
// ----------------------------------------------------------------------------
`default_nettype none

import dsld_pkg::*;

// one predicted or observed parser result
typedef struct packed {
    logic [1:0] code;
    logic [7:0] data;
    logic       kind;
    logic       last;
} frame_event_t;

// frame parser copy plus the queue of results it still waits for
class frame_event_scoreboard;
    logic [31:0]  max_len;
    logic [2:0]   phase;
    logic         kind;
    logic [31:0]  len_acc;
    logic [1:0]   len_idx;
    logic [31:0]  remaining;
    frame_event_t pending_events[$];
    int           errors;

    function new();
        max_len   = MAX_LEN_RESET;
        phase     = PH_HUNT;
        kind      = 1'b0;
        len_acc   = '0;
        len_idx   = '0;
        remaining = '0;
        errors    = 0;
    endfunction

    function void set_max_len(logic [31:0] value);
        max_len = value;
    endfunction

    // advance the parser by one accepted byte
    function void take_byte(logic [7:0] b);
        frame_event_t ev;
        logic         hit;
        ev  = '0;
        hit = 1'b0;
        case (phase)
            PH_MSG_B, PH_RAW_B:
            begin
                if (b == ((phase == PH_MSG_B) ? SYNC_MSG_B : SYNC_RAW_B))
                begin
                    phase   = PH_LEN;
                    len_acc = '0;
                    len_idx = '0;
                end
                else
                begin
                    phase   = PH_HUNT;
                    hit     = 1'b1;
                    ev.code = EV_SYNCERR;
                end
            end
            PH_LEN:
            begin
                len_acc = len_acc | ({24'd0, b} << (8 * len_idx));
                if (len_idx != 2'd3)
                begin
                    len_idx = len_idx + 2'd1;
                end
                else
                begin
                    len_idx = '0;
                    if (len_acc == 32'd0)
                    begin
                        phase   = PH_HUNT;
                        hit     = 1'b1;
                        ev.code = EV_EMPTY;
                        ev.last = 1'b1;
                    end
                    else
                    begin
                        remaining = len_acc;
                        if (len_acc > max_len)
                        begin
                            phase   = PH_SKIP;
                            hit     = 1'b1;
                            ev.code = EV_OVERSIZE;
                        end
                        else
                        begin
                            phase = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                remaining = remaining - 32'd1;
                hit       = 1'b1;
                ev.code   = EV_DATA;
                ev.data   = b;
                ev.last   = (remaining == 32'd0);
                if (remaining == 32'd0)
                    phase = PH_HUNT;
            end
            PH_SKIP:
            begin
                remaining = remaining - 32'd1;
                if (remaining == 32'd0)
                    phase = PH_HUNT;
            end
            default:
            begin
                if (b == SYNC_MSG_A)
                begin
                    kind  = 1'b0;
                    phase = PH_MSG_B;
                end
                else if (b == SYNC_RAW_A)
                begin
                    kind  = 1'b1;
                    phase = PH_RAW_B;
                end
                else
                begin
                    phase = PH_HUNT;
                end
            end
        endcase
        ev.kind = kind;
        if (hit)
            pending_events.push_back(ev);
    endfunction

    // compare one accepted result against the oldest prediction
    function void match_event(frame_event_t got);
        frame_event_t want;
        if (pending_events.size() == 0)
        begin
            $display("%0t: unexpected result event %0d byte %0h kind %0d last %0d",
                     $time, got.code, got.data, got.kind, got.last);
            errors++;
            return;
        end
        want = pending_events.pop_front();
        if (got.code !== want.code)
        begin
            $display("%0t: event_res expected %0d actual %0d", $time, want.code, got.code);
            errors++;
        end
        if (got.data !== want.data)
        begin
            $display("%0t: payload_byte expected %0h actual %0h", $time, want.data, got.data);
            errors++;
        end
        if (got.kind !== want.kind)
        begin
            $display("%0t: frame_kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $display("%0t: last_of_frame expected %0d actual %0d", $time, want.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles without any handshake before the run is declared hung
    localparam int unsigned STALL_LIMIT = 2000;
    // cycles allowed for the input and result registers to empty
    localparam int unsigned DRAIN_CYCLES = 6;
    // bytes per random segment, six segments in all
    localparam int unsigned SEGMENT_BYTES = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  event_res;
    logic [7:0]  payload_byte;
    logic        frame_kind;
    logic        last_of_frame;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    frame_event_scoreboard sb = new();

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned quiet_cycles = 0;

    // payload limits per random segment, extremes included
    logic [31:0] seg_max_len [6] = '{32'd0, 32'd12, 32'hFFFF_FFFF, 32'd1, 32'd30,
                                     MAX_LEN_RESET};

    dual_sync_length_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .payload_byte  (payload_byte),
        .frame_kind    (frame_kind),
        .last_of_frame (last_of_frame),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver side: stall at random at the current rate
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // values read right after the edge are the ones the edge acted on
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.match_event('{code: event_res, data: payload_byte,
                                 kind: frame_kind, last: last_of_frame});
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            // watchdog: nothing moved for far too long
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // 0: sender rarely idles, receiver mostly stalls
    // 1: the other way round
    // 2: full rate on both sides
    task automatic set_idle_mode(input int unsigned mode);
        case (mode)
            0:
            begin
                tx_idle_pct  = 11;
                rx_stall_pct = 81;
            end
            1:
            begin
                tx_idle_pct  = 81;
                rx_stall_pct = 11;
            end
            default:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
        endcase
    endtask

    // offer one item, maybe after some idle cycles, and wait until taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    // drop valid, let every predicted result come out, then let the pipe settle
    task automatic drain;
        in_valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // only called with the block drained
    task automatic write_max_len(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_max_len(value);
    endtask

    task automatic send_header(input logic raw, input logic [31:0] len);
        send_byte(raw ? SYNC_RAW_A : SYNC_MSG_A);
        send_byte(raw ? SYNC_RAW_B : SYNC_MSG_B);
        for (int i = 0; i < 4; i++)
            send_byte(len[8 * i +: 8]);
    endtask

    task automatic send_frame(input logic raw, input int unsigned len);
        send_header(raw, len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // mostly good frames; noise and broken syncs always leave the parser hunting
    task automatic run_random(input int unsigned n_bytes);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        logic        raw;
        logic [7:0]  b;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            pick = $urandom_range(0, 99);
            raw  = 1'($urandom_range(0, 1));
            if (pick < 80)
            begin
                // short lengths mostly, some long enough to trip small limits
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    len = 0;
                else if (pick < 80)
                    len = $urandom_range(1, 12);
                else
                    len = $urandom_range(13, 40);
                send_frame(raw, len);
            end
            else if (pick < 90)
            begin
                // stray bytes that never start a sync pair
                repeat ($urandom_range(1, 3))
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == SYNC_MSG_A || b == SYNC_RAW_A);
                    send_byte(b);
                end
            end
            else
            begin
                // good first sync byte, wrong second one
                do
                    b = 8'($urandom_range(0, 255));
                while (b == (raw ? SYNC_RAW_B : SYNC_MSG_B));
                send_byte(raw ? SYNC_RAW_A : SYNC_MSG_A);
                send_byte(b);
            end
        end
    endtask

    initial
    begin
        set_idle_mode(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown bytes at both ends of the range are skipped
        send_byte(8'h00);
        send_byte(8'hFF);
        // bad second byte after a message sync
        send_byte(SYNC_MSG_A);
        send_byte(8'h00);
        // bad second byte that is itself a sync byte: used up, not rehunted
        send_byte(SYNC_RAW_A);
        send_byte(SYNC_MSG_A);
        // empty message frame
        send_header(1'b0, 32'd0);
        // one-byte raw frame, then a two-byte message frame
        send_header(1'b1, 32'd1);
        send_byte(8'hFF);
        send_header(1'b0, 32'd2);
        send_byte(8'h00);
        send_byte(8'h80);
        drain();

        // random segments, two per idle mode, each under its own limit
        for (int seg = 0; seg < 6; seg++)
        begin
            set_idle_mode(seg / 2);
            write_max_len(seg_max_len[seg]);
            run_random(SEGMENT_BYTES);
            drain();
        end

        // largest possible length is oversize under the last limit; the
        // parser then sits in its dropped-payload state for good
        send_header(1'b1, 32'hFFFF_FFFF);
        repeat (5) send_byte(8'($urandom_range(0, 255)));
        drain();
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.pending_events.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
